// ===== src/ufct_pkg.sv =====
// Package for the union-find component tracker: node id width, reset constants,
// controller state type and the result record passed from the engine to the top level.
// No dependencies.
package ufct_pkg;

  localparam int ID_W = 11;
  localparam logic [ID_W-1:0] NODE_COUNT_RST = 11'd1024;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_CMP,
    ST_SZ_A,
    ST_SZ_B,
    ST_LINK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0] component_total;
    logic [ID_W-1:0] largest_set;
    logic            bad_node;
  } result_t;

endpackage

// ===== src/ufct_ram.sv =====
// Simple dual-port synchronous RAM: one write port and one registered read port.
// Used for the parent and set size stores. No dependencies.
module ufct_ram #(
  parameter int DEPTH  = 1025,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ufct_engine.sv =====
// Union-find engine: init sweep, root walks with path compression, union by size.
// Owns the parent and set size memories (ufct_ram) and the count registers.
// Depends on ufct_pkg and ufct_ram.
module ufct_engine #(
  parameter int DEPTH  = 1025,
  parameter int ADDR_W = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       restart,
  input  logic [ufct_pkg::ID_W-1:0]  eff_count,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ufct_pkg::ID_W-1:0]  in_a,
  input  logic [ufct_pkg::ID_W-1:0]  in_b,
  output logic                       res_valid,
  input  logic                       res_ready,
  output ufct_pkg::result_t          res
);

  localparam int IW = ufct_pkg::ID_W;

  ufct_pkg::state_t state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [IW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic          bad_r, bad_nxt;
  logic          side_r, side_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] root_r, root_nxt;
  logic [IW-1:0] ra_r, ra_nxt;
  logic [IW-1:0] sa_r, sa_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [IW-1:0] max_r, max_nxt;

  logic              p_we, s_we;
  logic [ADDR_W-1:0] p_waddr, p_raddr, s_waddr, s_raddr;
  logic [IW-1:0]     p_wdata, p_rdata, s_wdata, s_rdata;

  logic          side_done;
  logic [IW-1:0] found;
  logic [IW-1:0] start;
  logic [IW-1:0] sum;
  logic          in_bad;

  ufct_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(IW)) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  ufct_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(IW)) u_size (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign in_bad = (in_a == '0) || (in_b == '0) || (in_a > eff_count) || (in_b > eff_count);
  assign start  = side_r ? b_r : a_r;
  assign sum    = sa_r + s_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ufct_pkg::ST_INIT;
      idx_r   <= '0;
      count_r <= ufct_pkg::NODE_COUNT_RST;
      max_r   <= IW'(1);
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      max_r   <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    bad_r  <= bad_nxt;
    side_r <= side_nxt;
    cur_r  <= cur_nxt;
    root_r <= root_nxt;
    ra_r   <= ra_nxt;
    sa_r   <= sa_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    bad_nxt   = bad_r;
    side_nxt  = side_r;
    cur_nxt   = cur_r;
    root_nxt  = root_r;
    ra_nxt    = ra_r;
    sa_nxt    = sa_r;
    count_nxt = count_r;
    max_nxt   = max_r;
    p_we      = 1'b0;
    p_waddr   = ADDR_W'(cur_r);
    p_wdata   = root_r;
    p_raddr   = ADDR_W'(cur_r);
    s_we      = 1'b0;
    s_waddr   = idx_r;
    s_wdata   = IW'(1);
    s_raddr   = ADDR_W'(ra_r);
    in_ready  = 1'b0;
    res_valid = 1'b0;
    side_done = 1'b0;
    found     = root_r;

    case (state_r)
      ufct_pkg::ST_INIT: begin
        p_we    = 1'b1;
        p_waddr = idx_r;
        p_wdata = IW'(idx_r);
        s_we    = 1'b1;
        if (idx_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ufct_pkg::ST_IDLE;
          count_nxt = eff_count;
          max_nxt   = IW'(1);
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      ufct_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          a_nxt   = in_a;
          b_nxt   = in_b;
          bad_nxt = in_bad;
          if (in_bad) begin
            state_nxt = ufct_pkg::ST_DONE;
          end else begin
            side_nxt  = 1'b0;
            cur_nxt   = in_a;
            p_raddr   = ADDR_W'(in_a);
            state_nxt = ufct_pkg::ST_WALK;
          end
        end
      end
      ufct_pkg::ST_WALK: begin
        if (p_rdata == cur_r) begin
          root_nxt = cur_r;
          found    = cur_r;
          if (start == cur_r) begin
            side_done = 1'b1;
          end else begin
            cur_nxt   = start;
            p_raddr   = ADDR_W'(start);
            state_nxt = ufct_pkg::ST_CMP;
          end
        end else begin
          cur_nxt = p_rdata;
          p_raddr = ADDR_W'(p_rdata);
        end
      end
      ufct_pkg::ST_CMP: begin
        p_we = 1'b1;
        if (p_rdata == root_r) begin
          side_done = 1'b1;
        end else begin
          cur_nxt = p_rdata;
          p_raddr = ADDR_W'(p_rdata);
        end
      end
      ufct_pkg::ST_SZ_A: begin
        s_raddr   = ADDR_W'(ra_r);
        state_nxt = ufct_pkg::ST_SZ_B;
      end
      ufct_pkg::ST_SZ_B: begin
        sa_nxt    = s_rdata;
        s_raddr   = ADDR_W'(root_r);
        state_nxt = ufct_pkg::ST_LINK;
      end
      ufct_pkg::ST_LINK: begin
        p_we    = 1'b1;
        s_we    = 1'b1;
        s_wdata = sum;
        if (sa_r < s_rdata) begin
          p_waddr = ADDR_W'(ra_r);
          p_wdata = root_r;
          s_waddr = ADDR_W'(root_r);
        end else begin
          p_waddr = ADDR_W'(root_r);
          p_wdata = ra_r;
          s_waddr = ADDR_W'(ra_r);
        end
        if (count_r > IW'(1)) begin
          count_nxt = count_r - IW'(1);
        end
        if (sum > max_r) begin
          max_nxt = sum;
        end
        state_nxt = ufct_pkg::ST_DONE;
      end
      ufct_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ufct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ufct_pkg::ST_INIT;
        idx_nxt   = '0;
      end
    endcase

    if (side_done) begin
      if (!side_r) begin
        ra_nxt    = found;
        side_nxt  = 1'b1;
        cur_nxt   = b_r;
        p_raddr   = ADDR_W'(b_r);
        state_nxt = ufct_pkg::ST_WALK;
      end else if (ra_r == found) begin
        state_nxt = ufct_pkg::ST_DONE;
      end else begin
        state_nxt = ufct_pkg::ST_SZ_A;
      end
    end

    if (restart) begin
      state_nxt = ufct_pkg::ST_INIT;
      idx_nxt   = '0;
    end
  end

  assign res.component_total = count_r;
  assign res.largest_set     = max_r;
  assign res.bad_node        = bad_r;

endmodule

// ===== src/union_find_component_tracker.sv =====
// Union-find component tracker: one edge word in, one component/size word out.
// A bad id goes straight to the result; otherwise parent walks from node_a and node_b,
// and on a merge two set size reads and a link (union by size keeps hops at 10 or
// fewer); one edge at a time, the next taken once the result is registered. Reset or
// a node_count write runs an init sweep over all MAX_NODES+1 (capped at 2048) entries
// of both RAMs; no edge is taken until it ends. Depends on ufct_pkg, ufct_engine.
module union_find_component_tracker #(
  parameter int MAX_NODES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,      // node_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,       // node_a [10:0], node_b [21:11], zero [23:22]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,      // component_total [10:0], largest_set [21:11], zero
  output logic        out_tuser       // bad_node
);

  localparam int IW     = ufct_pkg::ID_W;
  localparam int ID_MAX = (1 << IW) - 1;
  localparam int MAXN   = (MAX_NODES > ID_MAX) ? ID_MAX : MAX_NODES;
  localparam int DEPTH  = MAXN + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [IW-1:0] MAX_ID = IW'(MAXN);

  logic [IW-1:0] node_count_r;
  logic [IW-1:0] eff_count;

  logic              res_valid, res_ready;
  ufct_pkg::result_t res;

  logic              out_valid_r;
  ufct_pkg::result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= ufct_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (node_count_r == '0) begin
      eff_count = IW'(1);
    end else if (node_count_r > MAX_ID) begin
      eff_count = MAX_ID;
    end else begin
      eff_count = node_count_r;
    end
  end

  ufct_engine #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_we),
    .eff_count (eff_count),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_a      (in_tdata[10:0]),
    .in_b      (in_tdata[21:11]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.largest_set, out_r.component_total};
  assign out_tuser  = out_r.bad_node;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for union_find_component_tracker: streams edge words and
// checks every component/size word against a built-in union-find predictor.
// Depends on ufct_pkg and the tracker RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_N      = 1024;
  localparam int LIMIT      = 1000000;
  localparam int HOLD_LEN   = 500;
  localparam int MAX_REPORT = 10;

  typedef logic [ufct_pkg::ID_W-1:0] node_id_t;

  typedef struct packed {
    node_id_t node_b;
    node_id_t node_a;
  } link_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  union_find_component_tracker #(.MAX_NODES(MAX_N)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // Predictor state
  node_id_t parent_of [0:MAX_N];
  node_id_t set_size  [0:MAX_N];
  node_id_t components;
  node_id_t largest;
  node_id_t node_count_reg;

  link_req_t         pending_edges[$];
  ufct_pkg::result_t expected_totals[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent_cnt = 0;
  int taken_cnt = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic node_id_t active_nodes();
    if (node_count_reg == 0) return node_id_t'(1);
    if (node_count_reg > MAX_N) return node_id_t'(MAX_N);
    return node_count_reg;
  endfunction

  function automatic void restart_tracker(node_id_t cnt);
    node_count_reg = cnt;
    for (int i = 0; i <= MAX_N; i++) begin
      parent_of[i] = node_id_t'(i);
      set_size[i] = node_id_t'(1);
    end
    components = active_nodes();
    largest = node_id_t'(1);
  endfunction

  function automatic node_id_t root_of(node_id_t x);
    node_id_t r;
    node_id_t cur;
    node_id_t nxt;
    int steps;
    r = x;
    steps = 0;
    while (parent_of[r] != r && steps <= MAX_N) begin
      r = parent_of[r];
      steps++;
    end
    cur = x;
    steps = 0;
    while (cur != r && steps <= MAX_N) begin
      nxt = parent_of[cur];
      parent_of[cur] = r;
      cur = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic ufct_pkg::result_t apply_link(node_id_t a, node_id_t b);
    node_id_t n;
    node_id_t ra;
    node_id_t rb;
    node_id_t merged;
    ufct_pkg::result_t res;
    n = active_nodes();
    res.bad_node = 1'b0;
    if (a == 0 || b == 0 || a > n || b > n) begin
      res.bad_node = 1'b1;
    end else begin
      ra = root_of(a);
      rb = root_of(b);
      if (ra != rb) begin
        if (set_size[ra] < set_size[rb]) begin
          parent_of[ra] = rb;
          set_size[rb] = set_size[rb] + set_size[ra];
          merged = set_size[rb];
        end else begin
          parent_of[rb] = ra;
          set_size[ra] = set_size[ra] + set_size[rb];
          merged = set_size[ra];
        end
        if (components > 1) components = components - node_id_t'(1);
        if (merged > largest) largest = merged;
      end
    end
    res.component_total = components;
    res.largest_set = largest;
    return res;
  endfunction

  function automatic node_id_t pick_id(int n);
    if ($urandom_range(0, 99) < 88) return node_id_t'($urandom_range(1, n));
    return node_id_t'($urandom_range(0, 2047));
  endfunction

  // Driver: hold a word until taken, then offer the next one or idle
  always @(negedge clk) begin : drive_proc
    link_req_t nxt;
    if (rst_n && !(in_tvalid && taken_cnt != sent_cnt)) begin
      if (pending_edges.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_edges.pop_front();
        in_tdata <= {2'b00, nxt.node_b, nxt.node_a};
        in_tvalid <= 1'b1;
        sent_cnt++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: check results first, then predict for an accepted edge word
  always @(posedge clk) begin : monitor_proc
    ufct_pkg::result_t got;
    ufct_pkg::result_t want;
    ufct_pkg::result_t pred;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.component_total = out_tdata[10:0];
        got.largest_set = out_tdata[21:11];
        got.bad_node = out_tuser;
        if (expected_totals.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("unexpected result word: total %0d largest %0d bad %0b",
                     got.component_total, got.largest_set, got.bad_node);
        end else begin
          want = expected_totals.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
              $display("mismatch: total %0d/%0d largest %0d/%0d bad %0b/%0b (exp/act)",
                       want.component_total, got.component_total,
                       want.largest_set, got.largest_set, want.bad_node, got.bad_node);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pred = apply_link(in_tdata[10:0], in_tdata[21:11]);
        expected_totals = {expected_totals, pred};
        taken_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic queue_edge(node_id_t a, node_id_t b);
    link_req_t e;
    e.node_a = a;
    e.node_b = b;
    pending_edges = {pending_edges, e};
  endtask

  task automatic wait_drain();
    while (pending_edges.size() != 0 || taken_cnt != sent_cnt || expected_totals.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_node_count(logic [10:0] v);
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    restart_tracker(v);
  endtask

  task automatic random_phase(int n, int count, int sidle, int rstall, bit hold);
    write_node_count(n[10:0]);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < count / 2; i++) queue_edge(pick_id(n), pick_id(n));
    if (hold) hold_req++;
    wait_drain();
    for (int i = count / 2; i < count; i++) queue_edge(pick_id(n), pick_id(n));
    wait_drain();
  endtask

  initial begin
    restart_tracker(ufct_pkg::NODE_COUNT_RST);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default node count: bad ids, self loop, equal and unequal merges, same set
    queue_edge(0, 1);
    queue_edge(1, 0);
    queue_edge(1025, 1);
    queue_edge(2047, 2047);
    queue_edge(1, 1);
    queue_edge(1, 2);
    queue_edge(3, 1);
    queue_edge(1024, 1023);
    queue_edge(1024, 1);
    queue_edge(2, 1024);
    queue_edge(1024, 1024);
    wait_drain();

    write_node_count(1);
    queue_edge(1, 1);
    queue_edge(1, 2);
    queue_edge(2, 1);
    wait_drain();

    // zero is used as one
    write_node_count(0);
    queue_edge(1, 1);
    queue_edge(0, 0);
    queue_edge(2047, 1);
    wait_drain();

    // above the maximum is clamped
    write_node_count(2047);
    queue_edge(1024, 1);
    queue_edge(1025, 1025);
    queue_edge(1, 1024);
    wait_drain();

    random_phase(16, 150, 0, 0, 1'b0);
    random_phase(64, 300, 69, 0, 1'b0);
    random_phase(200, 300, 0, 69, 1'b0);
    random_phase(1024, 300, 10, 10, 1'b1);
    random_phase(1024, 290, 0, 0, 1'b0);

    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_totals.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
